// ===== hdl/json_string_unescape_utf8_macros.svh =====
// ----------------------------------------------------------------------------
// json string unescape assertion macros
// shared concurrent assertion wrappers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JSU_ASSERT(lbl, prop, msg)
`define JSU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// types and constants shared by the json string unescape blocks
// ----------------------------------------------------------------------------
package jsu_pkg;

  // scanner phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_STR    = 3'd1,
    PH_ESC    = 3'd2,
    PH_HEX1   = 3'd3,
    PH_NEEDBS = 3'd4,
    PH_NEEDU  = 3'd5,
    PH_HEX2   = 3'd6
  } phase_t;

  // error codes reported on a result beat
  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_BAD_ESC       = 3'd1,
    ERR_BAD_HEX       = 3'd2,
    ERR_LONE_LOW      = 3'd3,
    ERR_UNPAIRED_HIGH = 3'd4,
    ERR_NUL           = 3'd5,
    ERR_NO_QUOTE      = 3'd6
  } err_t;

  localparam int unsigned CP_W = 21;

  // one unit of work from the scanner to the emitter
  typedef struct packed {
    logic            utf8;        // cp is a code point to encode
    logic [CP_W-1:0] cp;          // code point, or raw byte in the low bits
    logic            byte_valid;
    logic            done;
    err_t            err;
  } job_t;

endpackage

// ===== hdl/json_string_unescape_utf8.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// json string literal unescaper with utf-16 surrogate joining and utf-8 out
//
//   channel  direction  handshake          beat
//   input    in         push / full        in_byte
//   result   out        empty / pop        out_byte, out_byte_valid,
//                                          out_last_of_run, out_string_done,
//                                          out_error_code
//
// one input byte is taken every cycle while full is low; the emitter sends
// one result beat per cycle while pop is high, a completed \u escape expanding
// to up to four. the job of an accepted byte is written to the job queue
// at the accepting edge and its beats then loaded into the output register.
// full follows the JOB_DEPTH entry job queue, so pop held low backs up into
// the input once the output register and the queue are both full.
// synchronous reset clears the scan phase, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 import jsu_pkg::*; #(
  parameter int unsigned JOB_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last_of_run,
  output logic       out_string_done,
  output logic [2:0] out_error_code
);

  logic in_accept;
  logic job_push;
  job_t job_in;
  logic job_pop;
  logic job_valid;
  job_t job_head;

  assign in_accept = push && !full;

  // scanner
  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_byte   (in_byte),
    .job_push  (job_push),
    .job       (job_in)
  );

  // job queue
  jsu_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .din       (job_in),
    .full      (full),
    .pop       (job_pop),
    .not_empty (job_valid),
    .dout      (job_head)
  );

  // emitter
  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (job_valid),
    .job             (job_head),
    .job_pop         (job_pop),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_last_of_run (out_last_of_run),
    .out_string_done (out_string_done),
    .out_error_code  (out_error_code)
  );

endmodule

// ===== hdl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// byte scanner: tracks string and escape phase, gathers hex groups and
// joins surrogates, issues one job per byte that gives results
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_macros.svh"

module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  logic [7:0] in_byte,
  output logic       job_push,
  output job_t       job
);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [5:0] HI_TAG    = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0] LO_TAG    = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

  phase_t       phase_r, phase_nxt;
  logic [1:0]   hex_cnt_r, hex_cnt_nxt;
  logic [11:0]  acc_r, acc_nxt;
  logic [9:0]   high_r, high_nxt;

  logic         is_nul, is_quote, is_bslash, is_u;
  logic         hex_ok;
  logic [3:0]   digit;
  logic         last_digit;
  logic [15:0]  code_w;
  logic         hi_rng, lo_rng;
  logic         esc_ok;
  logic [7:0]   esc_byte;
  logic         fail;
  err_t         fail_code;

  // character classes
  assign is_nul    = (in_byte == CH_NUL);
  assign is_quote  = (in_byte == CH_QUOTE);
  assign is_bslash = (in_byte == CH_BSLASH);
  assign is_u      = (in_byte == CH_U);

  // hex digit decode, either case
  always_comb begin
    hex_ok = 1'b1;
    digit  = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      digit = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      digit = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      digit = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // one-letter escapes
  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_byte;
    unique case (in_byte)
      8'h6E: esc_byte = 8'h0A;
      8'h74: esc_byte = 8'h09;
      8'h72: esc_byte = 8'h0D;
      8'h62: esc_byte = 8'h08;
      8'h66: esc_byte = 8'h0C;
      CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = in_byte;
      default: esc_ok = 1'b0;
    endcase
  end

  // completed hex group
  assign last_digit = (hex_cnt_r == 2'd3);
  assign code_w     = {acc_r, digit};
  assign hi_rng     = (code_w[15:10] == HI_TAG);
  assign lo_rng     = (code_w[15:10] == LO_TAG);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_accept) begin
      unique case (phase_r)
        PH_STR: begin
          priority if (is_nul || is_quote) phase_nxt = PH_IDLE;
          else if (is_bslash)              phase_nxt = PH_ESC;
          else                             phase_nxt = PH_STR;
        end
        PH_ESC: begin
          priority if (is_u)        phase_nxt = PH_HEX1;
          else if (esc_ok)          phase_nxt = PH_STR;
          else                      phase_nxt = PH_IDLE;
        end
        PH_NEEDBS: phase_nxt = is_bslash ? PH_NEEDU : PH_IDLE;
        PH_NEEDU:  phase_nxt = is_u ? PH_HEX2 : PH_IDLE;
        PH_HEX1: begin
          priority if (!hex_ok) phase_nxt = PH_IDLE;
          else if (!last_digit) phase_nxt = PH_HEX1;
          else if (hi_rng)      phase_nxt = PH_NEEDBS;
          else if (lo_rng)      phase_nxt = PH_IDLE;
          else                  phase_nxt = PH_STR;
        end
        PH_HEX2: begin
          priority if (!hex_ok) phase_nxt = PH_IDLE;
          else if (!last_digit) phase_nxt = PH_HEX2;
          else if (lo_rng)      phase_nxt = PH_STR;
          else                  phase_nxt = PH_IDLE;
        end
        default: phase_nxt = is_quote ? PH_STR : PH_IDLE;
      endcase
    end
  end

  // job issue and datapath updates
  always_comb begin
    job_push    = 1'b0;
    job         = '0;
    job.err     = ERR_NONE;
    fail        = 1'b0;
    fail_code   = ERR_NONE;
    hex_cnt_nxt = hex_cnt_r;
    acc_nxt     = acc_r;
    high_nxt    = high_r;
    if (in_accept) begin
      hex_cnt_nxt = 2'd0;
      acc_nxt     = '0;
      unique case (phase_r)
        PH_STR: begin
          priority if (is_nul) begin
            fail = 1'b1; fail_code = ERR_NUL;
          end else if (is_quote) begin
            job_push = 1'b1;
            job.done = 1'b1;
          end else if (!is_bslash) begin
            job_push       = 1'b1;
            job.cp         = CP_W'(in_byte);
            job.byte_valid = 1'b1;
          end else begin
            // backslash opens an escape, no beat
            job_push = 1'b0;
          end
        end
        PH_ESC: begin
          priority if (is_nul) begin
            fail = 1'b1; fail_code = ERR_NUL;
          end else if (is_u) begin
            job_push = 1'b0;
          end else if (esc_ok) begin
            job_push       = 1'b1;
            job.cp         = CP_W'(esc_byte);
            job.byte_valid = 1'b1;
          end else begin
            fail = 1'b1; fail_code = ERR_BAD_ESC;
          end
        end
        PH_NEEDBS: begin
          priority if (is_nul) begin
            fail = 1'b1; fail_code = ERR_NUL;
          end else if (!is_bslash) begin
            fail = 1'b1; fail_code = ERR_UNPAIRED_HIGH;
          end else begin
            job_push = 1'b0;
          end
        end
        PH_NEEDU: begin
          priority if (is_nul) begin
            fail = 1'b1; fail_code = ERR_NUL;
          end else if (!is_u) begin
            fail = 1'b1; fail_code = ERR_UNPAIRED_HIGH;
          end else begin
            job_push = 1'b0;
          end
        end
        PH_HEX1, PH_HEX2: begin
          priority if (is_nul) begin
            fail = 1'b1; fail_code = ERR_NUL;
          end else if (!hex_ok) begin
            fail = 1'b1; fail_code = ERR_BAD_HEX;
          end else if (!last_digit) begin
            hex_cnt_nxt = hex_cnt_r + 2'd1;
            acc_nxt     = {acc_r[7:0], digit};
          end else if (phase_r == PH_HEX1) begin
            priority if (hi_rng) begin
              high_nxt = code_w[9:0];
            end else if (lo_rng) begin
              fail = 1'b1; fail_code = ERR_LONE_LOW;
            end else begin
              job_push       = 1'b1;
              job.utf8       = 1'b1;
              job.cp         = CP_W'(code_w);
              job.byte_valid = 1'b1;
            end
          end else begin
            priority if (lo_rng) begin
              job_push       = 1'b1;
              job.utf8       = 1'b1;
              job.cp         = SUPP_BASE + CP_W'({high_r, code_w[9:0]});
              job.byte_valid = 1'b1;
            end else begin
              fail = 1'b1; fail_code = ERR_UNPAIRED_HIGH;
            end
          end
        end
        default: begin
          if (!is_quote) begin
            fail = 1'b1; fail_code = ERR_NO_QUOTE;
          end
        end
      endcase
      // any error gives a single flagged beat
      if (fail) begin
        job_push = 1'b1;
        job      = '0;
        job.err  = fail_code;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      hex_cnt_r <= 2'd0;
      acc_r     <= '0;
      high_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      acc_r     <= acc_nxt;
      high_r    <= high_nxt;
    end
  end

  `JSU_ASSERT(a_front_group_closes,
    (in_accept && (phase_r == PH_HEX1 || phase_r == PH_HEX2) && hex_cnt_r == 2'd3)
      |=> (hex_cnt_r == 2'd0),
    "hex digit count not cleared after a group")
  `JSU_ASSERT(a_front_cp_no_err,
    (job_push && job.utf8) |-> (job.err == ERR_NONE && job.byte_valid),
    "code point job carries an error")

endmodule

// ===== hdl/jsu_fifo.sv =====
// ----------------------------------------------------------------------------
// jsu_fifo
// short job queue between scanner and emitter
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_macros.svh"

module jsu_fifo import jsu_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t dout
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign dout      = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `JSU_ASSERT(a_fifo_no_overflow, push |-> (!full || pop), "job written into a full queue")
  `JSU_ASSERT(a_fifo_no_underflow, pop |-> not_empty, "job taken from an empty queue")
  `JSU_ASSERT_ALWAYS(a_fifo_reset_empty, !rst_n |=> (count_r == '0), "queue not empty after reset")

endmodule

// ===== hdl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// result emitter: expands each job into one to four utf-8 beats and holds
// the current beat in an output register
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_macros.svh"

module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last_of_run,
  output logic       out_string_done,
  output logic [2:0] out_error_code
);

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;
  localparam logic [CP_W-1:0] LIM1 = 21'h80;
  localparam logic [CP_W-1:0] LIM2 = 21'h800;
  localparam logic [CP_W-1:0] LIM3 = 21'h10000;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r;
  logic       bvalid_r, last_r, done_r;
  logic [2:0] err_r;

  logic [1:0] last_idx;
  logic [7:0] enc [4];
  logic       load;
  logic       beat_last;

  // encoded length minus one
  always_comb begin
    priority if (!job.utf8 || job.cp < LIM1) last_idx = 2'd0;
    else if (job.cp < LIM2)                  last_idx = 2'd1;
    else if (job.cp < LIM3)                  last_idx = 2'd2;
    else                                     last_idx = 2'd3;
  end

  // utf-8 bytes of the head job
  always_comb begin
    enc[0] = job.cp[7:0];
    enc[1] = CONT | {2'b00, job.cp[5:0]};
    enc[2] = CONT | {2'b00, job.cp[5:0]};
    enc[3] = CONT | {2'b00, job.cp[5:0]};
    unique case (last_idx)
      2'd1: begin
        enc[0] = LEAD2 | {3'b000, job.cp[10:6]};
      end
      2'd2: begin
        enc[0] = LEAD3 | {4'b0000, job.cp[15:12]};
        enc[1] = CONT  | {2'b00, job.cp[11:6]};
      end
      2'd3: begin
        enc[0] = LEAD4 | {5'b00000, job.cp[20:18]};
        enc[1] = CONT  | {2'b00, job.cp[17:12]};
        enc[2] = CONT  | {2'b00, job.cp[11:6]};
      end
      default: enc[0] = job.cp[7:0];
    endcase
  end

  // beat sequencing
  assign beat_last = (idx_r == last_idx);
  assign load      = job_valid && (!out_valid_r || pop);
  assign job_pop   = load && beat_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = beat_last ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= enc[idx_r];
      bvalid_r <= job.byte_valid;
      last_r   <= beat_last;
      done_r   <= job.done;
      err_r    <= job.err;
    end
  end

  assign empty           = !out_valid_r;
  assign out_byte        = byte_r;
  assign out_byte_valid  = bvalid_r;
  assign out_last_of_run = last_r;
  assign out_string_done = done_r;
  assign out_error_code  = err_r;

  `JSU_ASSERT(a_back_job_held, (idx_r != 2'd0) |-> job_valid, "job left the queue mid expansion")
  `JSU_ASSERT(a_back_beat_held, (out_valid_r && !pop) |=> (out_valid_r && $stable(byte_r)), "waiting beat changed before it was taken")

endmodule

// ===== tb/json_string_unescape_utf8_tb.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb
// self-checking bench for the json string unescaper: a stimulus table and
// random json strings go in through push/full in random bursts, every result
// beat is popped under a changing stall pattern and compared field by field
// with a typed table entry or a behavioral decoder that tracks the scan phase and surrogate pairing
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam int         DIR_N     = 29;
  localparam int         RAND_N    = 360;
  localparam int         DRAIN_CYC = 16;

  // one result beat as seen on the out_ ports
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       done;
    err_t       err;
  } beat_t;

  // one input byte, with a typed-in expectation where it is obvious
  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    beat_t      want;
  } text_row_t;

  localparam beat_t NO_BEAT = '{8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_last_of_run;
  logic       out_string_done;
  logic [2:0] out_error_code;

  json_string_unescape_utf8 dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_last_of_run (out_last_of_run),
    .out_string_done (out_string_done),
    .out_error_code  (out_error_code)
  );

  // directed text: idle errors, raw extremes, escapes, a surrogate pair,
  // closing quote, nul in a string, bad escape letter, bad hex digit
  text_row_t dir_rows [DIR_N] = '{
    '{8'h00,     1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, ERR_NO_QUOTE}},
    '{8'hFF,     1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, ERR_NO_QUOTE}},
    '{CH_QUOTE,  1'b0, NO_BEAT},
    '{8'h01,     1'b0, NO_BEAT},
    '{8'hFF,     1'b0, NO_BEAT},
    '{CH_BSLASH, 1'b0, NO_BEAT},
    '{"/",       1'b0, NO_BEAT},
    '{CH_BSLASH, 1'b0, NO_BEAT},
    '{CH_U,      1'b0, NO_BEAT},
    '{"D",       1'b0, NO_BEAT},
    '{"8",       1'b0, NO_BEAT},
    '{"3",       1'b0, NO_BEAT},
    '{"D",       1'b0, NO_BEAT},
    '{CH_BSLASH, 1'b0, NO_BEAT},
    '{CH_U,      1'b0, NO_BEAT},
    '{"d",       1'b0, NO_BEAT},
    '{"E",       1'b0, NO_BEAT},
    '{"0",       1'b0, NO_BEAT},
    '{"0",       1'b0, NO_BEAT},
    '{CH_QUOTE,  1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE}},
    '{CH_QUOTE,  1'b0, NO_BEAT},
    '{8'h00,     1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, ERR_NUL}},
    '{CH_QUOTE,  1'b0, NO_BEAT},
    '{CH_BSLASH, 1'b0, NO_BEAT},
    '{"x",       1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, ERR_BAD_ESC}},
    '{CH_QUOTE,  1'b0, NO_BEAT},
    '{CH_BSLASH, 1'b0, NO_BEAT},
    '{CH_U,      1'b0, NO_BEAT},
    '{"G",       1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, ERR_BAD_HEX}}
  };

  logic [7:0] esc_letters [8] = '{"n", "t", "r", "b", "f", CH_QUOTE, CH_BSLASH, "/"};

  text_row_t text_q [$];
  beat_t     decoded_due [$];
  beat_t     step_out [$];
  int        mismatches = 0;
  logic      feed_done = 1'b0;

  // decoder state
  phase_t      scan_phase = PH_IDLE;
  logic [1:0]  hex_cnt = 2'd0;
  logic [15:0] hex_acc = 16'h0000;
  logic [15:0] high_half = 16'h0000;

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // decoder
  // ---------------------------------------------------------------------------

  function automatic void add_beat(logic [7:0] data, logic valid, logic done, err_t err);
    step_out.push_back('{data, valid, 1'b0, done, err});
  endfunction

  // any error drops back to idle with a single beat
  function automatic void scan_fail(err_t err);
    scan_phase = PH_IDLE;
    hex_cnt    = 2'd0;
    hex_acc    = 16'h0000;
    add_beat(8'h00, 1'b0, 1'b0, err);
  endfunction

  // utf-8 encoding of one code point
  function automatic void put_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      add_beat(cp[7:0], 1'b1, 1'b0, ERR_NONE);
    end else if (cp < 21'h800) begin
      add_beat({3'b110, cp[10:6]}, 1'b1, 1'b0, ERR_NONE);
      add_beat({2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
    end else if (cp < 21'h10000) begin
      add_beat({4'b1110, cp[15:12]}, 1'b1, 1'b0, ERR_NONE);
      add_beat({2'b10, cp[11:6]}, 1'b1, 1'b0, ERR_NONE);
      add_beat({2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
    end else begin
      add_beat({5'b11110, cp[20:18]}, 1'b1, 1'b0, ERR_NONE);
      add_beat({2'b10, cp[17:12]}, 1'b1, 1'b0, ERR_NONE);
      add_beat({2'b10, cp[11:6]}, 1'b1, 1'b0, ERR_NONE);
      add_beat({2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
    end
  endfunction

  // result beats caused by one text byte, left in step_out
  function automatic void decode_text_byte(logic [7:0] c);
    logic [3:0]  nib;
    logic        is_hex;
    logic [15:0] cw;
    step_out.delete();
    if (scan_phase == PH_IDLE) begin
      if (c == CH_QUOTE) scan_phase = PH_STR;
      else scan_fail(ERR_NO_QUOTE);
    end else if (c == 8'h00) begin
      scan_fail(ERR_NUL);
    end else begin
      case (scan_phase)
        PH_STR: begin
          if (c == CH_QUOTE) begin
            scan_phase = PH_IDLE;
            add_beat(8'h00, 1'b0, 1'b1, ERR_NONE);
          end else if (c == CH_BSLASH) begin
            scan_phase = PH_ESC;
          end else begin
            add_beat(c, 1'b1, 1'b0, ERR_NONE);
          end
        end
        PH_ESC: begin
          scan_phase = PH_STR;
          case (c)
            "n": add_beat(8'h0A, 1'b1, 1'b0, ERR_NONE);
            "t": add_beat(8'h09, 1'b1, 1'b0, ERR_NONE);
            "r": add_beat(8'h0D, 1'b1, 1'b0, ERR_NONE);
            "b": add_beat(8'h08, 1'b1, 1'b0, ERR_NONE);
            "f": add_beat(8'h0C, 1'b1, 1'b0, ERR_NONE);
            CH_QUOTE, CH_BSLASH, "/": add_beat(c, 1'b1, 1'b0, ERR_NONE);
            CH_U: begin
              scan_phase = PH_HEX1;
              hex_cnt    = 2'd0;
              hex_acc    = 16'h0000;
            end
            default: scan_fail(ERR_BAD_ESC);
          endcase
        end
        PH_NEEDBS: begin
          if (c != CH_BSLASH) scan_fail(ERR_UNPAIRED_HIGH);
          else scan_phase = PH_NEEDU;
        end
        PH_NEEDU: begin
          if (c != CH_U) begin
            scan_fail(ERR_UNPAIRED_HIGH);
          end else begin
            scan_phase = PH_HEX2;
            hex_cnt    = 2'd0;
            hex_acc    = 16'h0000;
          end
        end
        default: begin
          // first or second hex group
          is_hex = 1'b1;
          nib    = 4'h0;
          if (c >= "0" && c <= "9") nib = 4'(c - "0");
          else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
          else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
          else is_hex = 1'b0;
          if (!is_hex) begin
            scan_fail(ERR_BAD_HEX);
          end else begin
            cw = {hex_acc[11:0], nib};
            if (hex_cnt != 2'd3) begin
              hex_cnt = hex_cnt + 2'd1;
              hex_acc = cw;
            end else begin
              hex_cnt = 2'd0;
              hex_acc = 16'h0000;
              if (scan_phase == PH_HEX1) begin
                if (cw >= 16'hD800 && cw <= 16'hDBFF) begin
                  high_half  = cw;
                  scan_phase = PH_NEEDBS;
                end else if (cw >= 16'hDC00 && cw <= 16'hDFFF) begin
                  scan_fail(ERR_LONE_LOW);
                end else begin
                  scan_phase = PH_STR;
                  put_code_point({5'd0, cw});
                end
              end else if (cw < 16'hDC00 || cw > 16'hDFFF) begin
                scan_fail(ERR_UNPAIRED_HIGH);
              end else begin
                scan_phase = PH_STR;
                put_code_point(21'h10000 + {1'b0, high_half[9:0], cw[9:0]});
              end
            end
          end
        end
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // random json text
  // ---------------------------------------------------------------------------

  function automatic void add_input(logic [7:0] ch);
    text_q.push_back('{ch, 1'b0, NO_BEAT});
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return "0" + 8'(nib);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(nib) - 8'd10;
  endfunction

  function automatic void add_escape(logic [15:0] cw);
    add_input(CH_BSLASH);
    add_input(CH_U);
    add_input(hex_char(cw[15:12]));
    add_input(hex_char(cw[11:8]));
    add_input(hex_char(cw[7:4]));
    add_input(hex_char(cw[3:0]));
  endfunction

  // one string, mostly well formed, sometimes broken off by an error
  function automatic void gen_string();
    int          nseg;
    int          kind;
    logic [7:0]  ch;
    logic [15:0] cw;
    // stray byte in idle now and then
    if ($urandom_range(0, 9) == 0) begin
      do ch = 8'($urandom); while (ch == CH_QUOTE);
      add_input(ch);
    end
    add_input(CH_QUOTE);
    nseg = $urandom_range(0, 8);
    for (int i = 0; i < nseg; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        ch = 8'($urandom_range(1, 255));
        if (ch == CH_QUOTE || ch == CH_BSLASH) ch = ch + 8'd1;
        add_input(ch);
      end else if (kind < 55) begin
        add_input(CH_BSLASH);
        add_input(esc_letters[$urandom_range(0, 7)]);
      end else if (kind < 75) begin
        case ($urandom_range(0, 3))
          0:       cw = 16'($urandom_range(0, 'h7F));
          1:       cw = 16'($urandom_range('h80, 'h7FF));
          2:       cw = 16'($urandom_range('h800, 'hD7FF));
          default: cw = 16'($urandom_range('hE000, 'hFFFF));
        endcase
        add_escape(cw);
      end else if (kind < 90) begin
        add_escape(16'($urandom_range('hD800, 'hDBFF)));
        add_escape(16'($urandom_range('hDC00, 'hDFFF)));
      end else begin
        // broken sequence, the string ends at the error
        case ($urandom_range(0, 6))
          0: begin
            do ch = 8'($urandom_range(1, 255));
            while (ch inside {"n", "t", "r", "b", "f", CH_QUOTE, CH_BSLASH, "/", CH_U});
            add_input(CH_BSLASH);
            add_input(ch);
          end
          1: begin
            add_input(CH_BSLASH);
            add_input(CH_U);
            repeat ($urandom_range(0, 3)) add_input(hex_char(4'($urandom)));
            do ch = 8'($urandom_range(1, 255));
            while (ch inside {["0":"9"], ["a":"f"], ["A":"F"]});
            add_input(ch);
          end
          2: add_escape(16'($urandom_range('hDC00, 'hDFFF)));
          3: begin
            add_escape(16'($urandom_range('hD800, 'hDBFF)));
            do ch = 8'($urandom_range(1, 255)); while (ch == CH_BSLASH);
            add_input(ch);
          end
          4: begin
            add_escape(16'($urandom_range('hD800, 'hDBFF)));
            add_input(CH_BSLASH);
            do ch = 8'($urandom_range(1, 255)); while (ch == CH_U);
            add_input(ch);
          end
          5: begin
            add_escape(16'($urandom_range('hD800, 'hDBFF)));
            do cw = 16'($urandom); while (cw >= 16'hDC00 && cw <= 16'hDFFF);
            add_escape(cw);
          end
          default: begin
            // nul in any phase after the opening quote
            case ($urandom_range(0, 4))
              0: ;
              1: add_input(CH_BSLASH);
              2: begin
                add_input(CH_BSLASH);
                add_input(CH_U);
                repeat ($urandom_range(0, 3)) add_input(hex_char(4'($urandom)));
              end
              3: add_escape(16'($urandom_range('hD800, 'hDBFF)));
              default: begin
                add_escape(16'($urandom_range('hD800, 'hDBFF)));
                add_input(CH_BSLASH);
                if ($urandom_range(0, 1)) begin
                  add_input(CH_U);
                  repeat ($urandom_range(0, 3)) add_input(hex_char(4'($urandom)));
                end
              end
            endcase
            add_input(8'h00);
          end
        endcase
        return;
      end
    end
    add_input(CH_QUOTE);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  initial begin : sender
    int        idle_left;
    int        burst_left;
    text_row_t row;
    idle_left  = 0;
    burst_left = 1;
    for (int i = 0; i < DIR_N; i++) text_q.push_back(dir_rows[i]);
    while (text_q.size() < DIR_N + RAND_N) gen_string();
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (text_q.size() > 0 || push) begin
      @(posedge clk);
      // beat taken at this edge
      if (push && !full) begin
        row = text_q.pop_front();
        decode_text_byte(row.ch);
        if (row.typed) decoded_due.push_back(row.want);
        else foreach (step_out[k]) decoded_due.push_back(step_out[k]);
      end
      // hold the beat while the block is full
      if (!(push && full)) begin
        if (text_q.size() == 0) begin
          push <= 1'b0;
        end else if (idle_left > 0) begin
          idle_left--;
          push    <= 1'b0;
          in_byte <= 8'($urandom);
        end else begin
          push    <= 1'b1;
          in_byte <= text_q[0].ch;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
    feed_done = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // receiver: pops on a stall pattern that is redrawn at random once its mask is used up
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, beat_t want, beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected data=%h valid=%b last=%b done=%b err=%0d, got data=%h valid=%b last=%b done=%b err=%0d",
               $realtime, what, want.data, want.valid, want.last, want.done, want.err,
               got.data, got.valid, got.last, got.done, got.err);
  endtask

  logic [15:0] pop_pat = 16'hFFFF;
  int          pat_pos = 0;

  always @(posedge clk) begin : receiver
    beat_t got;
    beat_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      // check the beat taken at this edge
      if (pop && !empty) begin
        got = '{out_byte, out_byte_valid, out_last_of_run, out_string_done,
                err_t'(out_error_code)};
        if (decoded_due.size() == 0) begin
          note_mismatch("beat with nothing expected", NO_BEAT, got);
        end else begin
          want = decoded_due.pop_front();
          if (got.data != want.data || got.valid != want.valid || got.last != want.last ||
              got.done != want.done || got.err != want.err)
            note_mismatch("result mismatch", want, got);
        end
      end
      // next stall pattern
      if (pat_pos == 15) begin
        case ($urandom_range(0, 3))
          0:       pop_pat = 16'hFFFF;
          1:       pop_pat = 16'($urandom & $urandom) | 16'h0001;
          2:       pop_pat = 16'h0001;
          default: pop_pat = 16'($urandom) | 16'h0001;
        endcase
      end
      pat_pos = (pat_pos + 1) % 16;
      pop <= pop_pat[pat_pos];
    end
  end

  // ---------------------------------------------------------------------------
  // reset, end of run
  // ---------------------------------------------------------------------------
  initial begin : main
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (!feed_done) @(posedge clk);
    while (decoded_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0 && decoded_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard limit on the run
  initial begin : watchdog
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_fifo.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8.sv
tb/json_string_unescape_utf8_tb.sv
